// File: sv/mandelbrot_escape_count_defines.svh
// Assertion macros shared by the escape counter modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef MANDELBROT_ESCAPE_COUNT_DEFINES_SVH
`define MANDELBROT_ESCAPE_COUNT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MEC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mec_pkg.sv
// Shared types, constants and saturation helper for the escape counter.
// Depends on nothing; used by the cell, the coordinate unit and the top level.
package mec_pkg;

  localparam int WordW    = 32;
  localparam int ProdW    = 64;
  localparam int CountW   = 16;
  localparam int FracBits = 28;
  localparam int NumCells = 4;

  localparam int LimitBit   = 2 * FracBits + 2;
  localparam bit HasLimit   = (LimitBit < ProdW);
  localparam int LimitShift = HasLimit ? LimitBit : ProdW - 1;

  typedef struct packed {
    logic                    valid;
    logic                    done;
    logic [CountW-1:0]       count;
    logic signed [WordW-1:0] zr;
    logic signed [WordW-1:0] zi;
    logic signed [WordW-1:0] cr;
    logic signed [WordW-1:0] ci;
  } mec_ctx_t;

  function automatic logic signed [WordW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [WordW-1:0] r;
    if (v[ProdW-1:WordW-1] == {(ProdW-WordW+1){v[ProdW-1]}}) begin
      r = $signed(v[WordW-1:0]);
    end else if (v[ProdW-1]) begin
      r = $signed({1'b1, {(WordW-1){1'b0}}});
    end else begin
      r = $signed({1'b0, {(WordW-1){1'b1}}});
    end
    return r;
  endfunction

endpackage

// File: sv/mec_cell.sv
// One iteration cell of the escape counter ring: products, then the z update.
// Depends on mec_pkg and the assertion macros header.
`include "mandelbrot_escape_count_defines.svh"

module mec_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [15:0]               max_iter_i,
  input  mec_pkg::mec_ctx_t         ctx_i,
  output mec_pkg::mec_ctx_t         ctx_o
);
  import mec_pkg::*;

  mec_ctx_t                ctx_a_q;
  logic                    active_d, active_q;
  logic signed [ProdW-1:0] r2_d, r2_q;
  logic signed [ProdW-1:0] i2_d, i2_q;
  logic signed [ProdW-1:0] zz_d, zz_q;
  logic [ProdW-1:0]        mag;
  logic                    escape;
  logic signed [ProdW-1:0] diff;
  logic signed [ProdW-1:0] diff_sh;
  logic signed [ProdW-1:0] zz_sh;
  logic signed [ProdW-1:0] nr;
  logic signed [ProdW-1:0] ni;
  mec_ctx_t                ctx_d, ctx_q;

  always_comb begin
    active_d = ctx_i.valid && !ctx_i.done && (ctx_i.count < max_iter_i);
    r2_d     = ProdW'(ctx_i.zr) * ProdW'(ctx_i.zr);
    i2_d     = ProdW'(ctx_i.zi) * ProdW'(ctx_i.zi);
    zz_d     = ProdW'(ctx_i.zr) * ProdW'(ctx_i.zi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_a_q  <= '0;
      active_q <= 1'b0;
    end else begin
      ctx_a_q  <= ctx_i;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= r2_d;
    i2_q <= i2_d;
    zz_q <= zz_d;
  end

  assign mag     = $unsigned(r2_q) + $unsigned(i2_q);
  assign escape  = HasLimit && ((mag >> LimitShift) != '0);
  assign diff    = r2_q - i2_q;
  assign diff_sh = diff >>> FracBits;
  assign zz_sh   = zz_q >>> (FracBits - 1);
  assign nr      = diff_sh + ProdW'(ctx_a_q.cr);
  assign ni      = zz_sh + ProdW'(ctx_a_q.ci);

  always_comb begin
    ctx_d = ctx_a_q;
    if (ctx_a_q.valid && !ctx_a_q.done) begin
      if (!active_q || escape) begin
        ctx_d.done = 1'b1;
      end else begin
        ctx_d.zr    = sat32(nr);
        ctx_d.zi    = sat32(ni);
        ctx_d.count = ctx_a_q.count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
    end else begin
      ctx_q <= ctx_d;
    end
  end

  assign ctx_o = ctx_q;

  `MEC_ASSERT_IMPL(a_done_sticks, clk_i, rst_ni, $past(ctx_i.valid && ctx_i.done, 2), ctx_o.valid && ctx_o.done, "finished pixel reopened in cell")
  `MEC_ASSERT_IMPL(a_count_step, clk_i, rst_ni, $past(ctx_i.valid, 2), (ctx_o.count == $past(ctx_i.count, 2)) || (ctx_o.count == $past(ctx_i.count, 2) + 16'd1), "count moved by more than one")
  `MEC_ASSERT_IMPL(a_open_counted, clk_i, rst_ni, ctx_o.valid && !ctx_o.done, ctx_o.count != 16'd0, "open pixel left a cell without an iteration")

endmodule

// File: sv/mec_coord.sv
// Forms the point c from the pixel offsets, the tile origin and the steps.
// Depends on mec_pkg for the word widths and the saturation helper.
module mec_coord #(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [COORD_BITS-1:0]    col_i,
  input  logic [COORD_BITS-1:0]    row_i,
  input  logic signed [31:0]       origin_re_i,
  input  logic signed [31:0]       origin_im_i,
  input  logic signed [31:0]       step_re_i,
  input  logic signed [31:0]       step_im_i,
  output logic                     valid_o,
  output logic signed [31:0]       c_re_o,
  output logic signed [31:0]       c_im_o
);
  import mec_pkg::*;

  localparam int MulW = COORD_BITS + WordW + 1;

  logic                   valid1_q;
  logic                   valid2_q;
  logic signed [MulW-1:0] prod_re_d, prod_re_q;
  logic signed [MulW-1:0] prod_im_d, prod_im_q;
  logic signed [ProdW-1:0] sum_re;
  logic signed [ProdW-1:0] sum_im;
  logic signed [WordW-1:0] c_re_q, c_im_q;

  assign prod_re_d = MulW'($signed({1'b0, col_i})) * MulW'(step_re_i);
  assign prod_im_d = MulW'($signed({1'b0, row_i})) * MulW'(step_im_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= start_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
  end

  assign sum_re = ProdW'(prod_re_q) + ProdW'(origin_re_i);
  assign sum_im = ProdW'(prod_im_q) + ProdW'(origin_im_i);

  always_ff @(posedge clk_i) begin
    c_re_q <= sat32(sum_re);
    c_im_q <= sat32(sum_im);
  end

  assign valid_o = valid2_q;
  assign c_re_o  = c_re_q;
  assign c_im_o  = c_im_q;

endmodule

// File: sv/mandelbrot_escape_count.sv
// Top level of the Mandelbrot escape-time counter with its register port.
// Depends on mec_pkg, mec_coord, mec_cell and the assertion macros header.
// One pixel is worked at a time. Its point c is formed by registering the
// products, then the sum; it then circulates through a ring of four iteration
// cells, each of which works one iteration (the three products are registered,
// then z is updated). The default iteration limit is 64; the next word can be
// accepted once the result is in the output register, even while that result
// is still stalled.
`include "mandelbrot_escape_count_defines.svh"

module mandelbrot_escape_count #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] col_i,
  input  logic [COORD_BITS-1:0] row_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           escape_count_o,
  output logic [COORD_BITS-1:0] out_col_o,
  output logic [COORD_BITS-1:0] out_row_o
);
  import mec_pkg::*;

  localparam logic [2:0] RegOriginRe = 3'd0;
  localparam logic [2:0] RegOriginIm = 3'd1;
  localparam logic [2:0] RegStepRe   = 3'd2;
  localparam logic [2:0] RegStepIm   = 3'd3;
  localparam logic [2:0] RegMaxIter  = 3'd4;

  logic signed [31:0]    origin_re_q, origin_im_q, step_re_q, step_im_q;
  logic [15:0]           max_iter_q;
  logic                  cfg_write;
  logic [2:0]            reg_index;

  logic                  in_accept;
  logic                  busy_d, busy_q;
  logic [COORD_BITS-1:0] col_q, row_q;

  logic                  coord_valid;
  logic signed [31:0]    c_re, c_im;
  mec_ctx_t              chain [NumCells+1];
  mec_ctx_t              ring_out;
  logic [NumCells:0]     slot_valid;
  logic                  take;

  logic                  out_valid_d, out_valid_q;
  logic [15:0]           escape_count_q;
  logic [COORD_BITS-1:0] out_col_q, out_row_q;

  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q <= '0;
      origin_im_q <= '0;
      step_re_q   <= '0;
      step_im_q   <= '0;
      max_iter_q  <= 16'd64;
    end else if (cfg_write) begin
      unique case (reg_index)
        RegOriginRe: origin_re_q <= $signed(pwdata);
        RegOriginIm: origin_im_q <= $signed(pwdata);
        RegStepRe:   step_re_q   <= $signed(pwdata);
        RegStepIm:   step_im_q   <= $signed(pwdata);
        RegMaxIter:  max_iter_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      RegOriginRe: prdata = origin_re_q;
      RegOriginIm: prdata = origin_im_q;
      RegStepRe:   prdata = step_re_q;
      RegStepIm:   prdata = step_im_q;
      RegMaxIter:  prdata = {16'd0, max_iter_q};
      default:     prdata = '0;
    endcase
  end

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  mec_coord #(
    .COORD_BITS (COORD_BITS)
  ) u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .col_i       (col_i),
    .row_i       (row_i),
    .origin_re_i (origin_re_q),
    .origin_im_i (origin_im_q),
    .step_re_i   (step_re_q),
    .step_im_i   (step_im_q),
    .valid_o     (coord_valid),
    .c_re_o      (c_re),
    .c_im_o      (c_im)
  );

  assign ring_out = chain[NumCells];
  assign take     = ring_out.valid && ring_out.done && (!out_valid_q || !out_stall_i);

  always_comb begin
    chain[0] = '0;
    if (coord_valid) begin
      chain[0].valid = 1'b1;
      chain[0].cr    = c_re;
      chain[0].ci    = c_im;
    end else if (ring_out.valid && !take) begin
      chain[0] = ring_out;
    end
  end

  assign slot_valid[0] = coord_valid;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    mec_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .max_iter_i (max_iter_q),
      .ctx_i      (chain[g]),
      .ctx_o      (chain[g+1])
    );
    assign slot_valid[g+1] = chain[g+1].valid;
  end

  always_comb begin
    busy_d = busy_q;
    if (in_accept) begin
      busy_d = 1'b1;
    end else if (take) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      escape_count_q <= ring_out.count;
      out_col_q      <= col_q;
      out_row_q      <= row_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = escape_count_q;
  assign out_col_o      = out_col_q;
  assign out_row_o      = out_row_q;

  `MEC_ASSERT_IMPL(a_single_pixel, clk_i, rst_ni, 1'b1, $countones(slot_valid) <= 1, "more than one pixel in flight")
  `MEC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, busy_q && !in_stall_o == 1'b0, "accepted word did not mark the block busy")
  `MEC_ASSERT_NEXT(a_take_frees, clk_i, rst_ni, take, out_valid_q && !busy_q, "finished pixel not moved to the output register")

endmodule
